>>> hw/rtl/bst_pkg.sv
// Shared types and constants for the byte stream tokenizer.
// Used by bst_front, bst_fifo, bst_back and byte_stream_tokenizer_top.
package bst_pkg;

  localparam int KIND_W  = 5;
  localparam int VALUE_W = 63;
  localparam int POS_W   = 16;
  localparam int TDATA_W = 104;

  // token kinds
  localparam logic [KIND_W-1:0] K_END       = 5'd0;
  localparam logic [KIND_W-1:0] K_CHAR      = 5'd1;
  localparam logic [KIND_W-1:0] K_ASSIGN    = 5'd2;
  localparam logic [KIND_W-1:0] K_SCOPE     = 5'd3;
  localparam logic [KIND_W-1:0] K_DOT2      = 5'd4;
  localparam logic [KIND_W-1:0] K_DOT3      = 5'd5;
  localparam logic [KIND_W-1:0] K_OROR      = 5'd6;
  localparam logic [KIND_W-1:0] K_BRACKETS  = 5'd7;
  localparam logic [KIND_W-1:0] K_ARROW     = 5'd8;
  localparam logic [KIND_W-1:0] K_EQEQ      = 5'd9;
  localparam logic [KIND_W-1:0] K_LE        = 5'd10;
  localparam logic [KIND_W-1:0] K_GE        = 5'd11;
  localparam logic [KIND_W-1:0] K_NE        = 5'd12;
  localparam logic [KIND_W-1:0] K_LT        = 5'd13;
  localparam logic [KIND_W-1:0] K_GT        = 5'd14;
  localparam logic [KIND_W-1:0] K_STR_BYTE  = 5'd15;
  localparam logic [KIND_W-1:0] K_STR_END   = 5'd16;
  localparam logic [KIND_W-1:0] K_NAME_BYTE = 5'd17;
  localparam logic [KIND_W-1:0] K_NAME_END  = 5'd18;
  localparam logic [KIND_W-1:0] K_PRINTF    = 5'd19;
  localparam logic [KIND_W-1:0] K_NUMBER    = 5'd20;
  localparam logic [KIND_W-1:0] K_BAD_ESC   = 5'd21;
  localparam logic [KIND_W-1:0] K_UNTERM    = 5'd22;

  localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   line;
    logic [POS_W-1:0]   col;
    logic               last;
  } tok_rec_t;

  // up to two records produced by one input word
  typedef struct packed {
    logic [1:0] cnt;
    tok_rec_t   rec0;
    tok_rec_t   rec1;
  } tok_pair_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic     avail;
    tok_rec_t rec;
  } q_head_t;

endpackage

>>> hw/rtl/bst_front.sv
// Front end: takes one byte word, runs the lexer state and line/column counters,
// and produces up to two token records for the queue. Depends on bst_pkg.
module bst_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  logic [7:0]                src_byte,
  input  logic                      eoi,
  output bst_pkg::tok_pair_t        pair
);

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_NUMBER, M_NAME, M_STRING, M_ESCAPE,
    M_COLON, M_DOT, M_DOT2, M_BAR, M_BRACK, M_MINUS, M_EQ, M_LT, M_GT,
    M_BANG, M_DONE
  } mode_t;

  typedef struct packed {
    mode_t                       mode;
    logic [bst_pkg::VALUE_W-1:0] acc;
    logic [2:0]                  kidx;
    logic                        emit;
    logic [bst_pkg::KIND_W-1:0]  kind;
    logic [bst_pkg::VALUE_W-1:0] value;
  } fresh_t;

  typedef struct packed {
    logic                        emit;
    logic [bst_pkg::KIND_W-1:0]  kind;
    logic [bst_pkg::VALUE_W-1:0] value;
  } emit_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_HASH  = "#";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_BAR   = "|";
  localparam logic [7:0] CH_LBRK  = "[";
  localparam logic [7:0] CH_RBRK  = "]";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_DQ    = "\"";
  localparam logic [7:0] CH_SQ    = "'";
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UNDER = "_";

  localparam logic [2:0] KW_LEN  = 3'd6;
  localparam logic [2:0] KW_MISS = 3'd7;
  localparam logic [7:0] KW_TEXT [6] = '{"p", "r", "i", "n", "t", "f"};

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  mode_t                       mode_r, mode_nxt;
  logic [bst_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [2:0]                  kidx_r, kidx_nxt;
  logic [POSITION_BITS-1:0]    line_r, line_nxt;
  logic [POSITION_BITS-1:0]    col_r, col_nxt;

  logic [1:0]                  n;
  logic [bst_pkg::KIND_W-1:0]  kind_s [2];
  logic [bst_pkg::VALUE_W-1:0] val_s  [2];
  logic                        do_pend, do_fresh, do_end;
  logic [bst_pkg::KIND_W-1:0]  pair_kind;
  logic [66:0]                 prod;
  logic [8:0]                  esc;
  fresh_t                      fr;
  emit_t                       pd;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return (c == CH_UNDER) || c[7] || ((c >= "a") && (c <= "z")) ||
           ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [2:0] track(input logic [2:0] k, input logic [7:0] c);
    logic [2:0] r;
    r = KW_MISS;
    if (k < KW_LEN) begin
      if (c == KW_TEXT[k]) r = k + 3'd1;
    end
    return r;
  endfunction

  // bit 8 set: known escape, low bits the resolved byte
  function automatic logic [8:0] esc_f(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_BSL:  r = {1'b1, CH_BSL};
      "0":     r = {1'b1, 8'd0};
      "n":     r = {1'b1, 8'd10};
      "t":     r = {1'b1, 8'd9};
      "r":     r = {1'b1, 8'd13};
      "f":     r = {1'b1, 8'd12};
      "v":     r = {1'b1, 8'd11};
      "a":     r = {1'b1, 8'd7};
      "e":     r = {1'b1, 8'd27};
      "b":     r = {1'b1, 8'd8};
      CH_SQ:   r = {1'b1, CH_SQ};
      CH_DQ:   r = {1'b1, CH_DQ};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // byte seen between tokens
  function automatic fresh_t fresh_f(input logic [7:0] c,
                                     input logic [bst_pkg::VALUE_W-1:0] acc,
                                     input logic [2:0] kidx);
    fresh_t r;
    r.mode  = M_IDLE;
    r.acc   = acc;
    r.kidx  = kidx;
    r.emit  = 1'b0;
    r.kind  = bst_pkg::K_CHAR;
    r.value = {{(bst_pkg::VALUE_W-8){1'b0}}, c};
    case (c)
      CH_NUL: begin
        r.emit  = 1'b1;
        r.kind  = bst_pkg::K_END;
        r.value = '0;
        r.mode  = M_DONE;
      end
      CH_SPACE, CH_TAB, CH_FF, CH_CR, CH_LF, CH_VT: r.mode = M_IDLE;
      CH_HASH:  r.mode = M_COMMENT;
      CH_COLON: r.mode = M_COLON;
      CH_DOT:   r.mode = M_DOT;
      CH_BAR:   r.mode = M_BAR;
      CH_LBRK:  r.mode = M_BRACK;
      CH_MINUS: r.mode = M_MINUS;
      CH_EQ:    r.mode = M_EQ;
      CH_LT:    r.mode = M_LT;
      CH_GT:    r.mode = M_GT;
      CH_BANG:  r.mode = M_BANG;
      CH_DQ:    r.mode = M_STRING;
      default: begin
        if (is_digit(c)) begin
          r.acc  = {{(bst_pkg::VALUE_W-8){1'b0}}, c - 8'h30};
          r.mode = M_NUMBER;
        end else if (is_name(c)) begin
          r.kidx = track(3'd0, c);
          r.emit = 1'b1;
          r.kind = bst_pkg::K_NAME_BYTE;
          r.mode = M_NAME;
        end else begin
          r.emit = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // token held while waiting on the lookahead byte
  function automatic emit_t pend_f(input mode_t m,
                                   input logic [bst_pkg::VALUE_W-1:0] acc,
                                   input logic [2:0] kidx);
    emit_t r;
    r.emit  = 1'b1;
    r.kind  = bst_pkg::K_CHAR;
    r.value = '0;
    case (m)
      M_COLON:  r.value[7:0] = CH_COLON;
      M_DOT:    r.value[7:0] = CH_DOT;
      M_DOT2:   r.kind = bst_pkg::K_DOT2;
      M_BAR:    r.value[7:0] = CH_BAR;
      M_BRACK:  r.value[7:0] = CH_LBRK;
      M_MINUS:  r.value[7:0] = CH_MINUS;
      M_EQ:     r.value[7:0] = CH_EQ;
      M_LT:     r.kind = bst_pkg::K_LT;
      M_GT:     r.kind = bst_pkg::K_GT;
      M_BANG:   r.value[7:0] = CH_BANG;
      M_NUMBER: begin
        r.kind  = bst_pkg::K_NUMBER;
        r.value = acc;
      end
      M_NAME:   r.kind = (kidx == KW_LEN) ? bst_pkg::K_PRINTF : bst_pkg::K_NAME_END;
      default:  r.emit = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    kidx_nxt  = kidx_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    n         = 2'd0;
    kind_s[0] = bst_pkg::K_END;
    kind_s[1] = bst_pkg::K_END;
    val_s[0]  = '0;
    val_s[1]  = '0;
    do_pend   = 1'b0;
    do_fresh  = 1'b0;
    do_end    = 1'b0;
    pair_kind = bst_pkg::K_END;
    // x*10 + d as (x<<3) + (x<<1) + d, wide enough to see the overflow
    prod      = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
              + {59'd0, src_byte - 8'h30};
    esc       = esc_f(src_byte);
    pd        = pend_f(mode_r, acc_r, kidx_r);

    if (take && (mode_r != M_DONE)) begin
      if (eoi) begin
        mode_nxt = M_DONE;
        if ((mode_r == M_STRING) || (mode_r == M_ESCAPE)) begin
          if (mode_r == M_ESCAPE) begin
            kind_s[n[0]] = bst_pkg::K_BAD_ESC;
            n = n + 2'd1;
          end
          kind_s[n[0]] = bst_pkg::K_UNTERM;
          n = n + 2'd1;
        end else begin
          do_pend = 1'b1;
          do_end  = 1'b1;
        end
      end else begin
        if (src_byte == CH_LF) begin
          line_nxt = line_r + POS_ONE;
          col_nxt  = '0;
        end else begin
          col_nxt  = col_r + POS_ONE;
        end

        case (mode_r)
          M_IDLE:    do_fresh = 1'b1;
          M_COMMENT: if (src_byte == CH_LF) mode_nxt = M_IDLE;
          M_STRING: begin
            if (src_byte == CH_DQ) begin
              kind_s[n[0]] = bst_pkg::K_STR_END;
              n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else if (src_byte == CH_BSL) begin
              mode_nxt = M_ESCAPE;
            end else begin
              kind_s[n[0]] = bst_pkg::K_STR_BYTE;
              val_s[n[0]]  = {{(bst_pkg::VALUE_W-8){1'b0}}, src_byte};
              n = n + 2'd1;
            end
          end
          M_ESCAPE: begin
            mode_nxt = M_STRING;
            if (esc[8]) begin
              kind_s[n[0]] = bst_pkg::K_STR_BYTE;
              val_s[n[0]]  = {{(bst_pkg::VALUE_W-8){1'b0}}, esc[7:0]};
              n = n + 2'd1;
            end else begin
              // unknown escape: error, then the byte again as string content
              kind_s[n[0]] = bst_pkg::K_BAD_ESC;
              val_s[n[0]]  = {{(bst_pkg::VALUE_W-8){1'b0}}, src_byte};
              n = n + 2'd1;
              kind_s[n[0]] = bst_pkg::K_STR_BYTE;
              val_s[n[0]]  = {{(bst_pkg::VALUE_W-8){1'b0}}, src_byte};
              n = n + 2'd1;
            end
          end
          M_NUMBER: begin
            if (is_digit(src_byte)) begin
              acc_nxt = (|prod[66:63]) ? bst_pkg::NUM_MAX : prod[62:0];
            end else begin
              do_pend  = 1'b1;
              do_fresh = 1'b1;
            end
          end
          M_NAME: begin
            if (is_name(src_byte) || is_digit(src_byte)) begin
              kidx_nxt = track(kidx_r, src_byte);
              kind_s[n[0]] = bst_pkg::K_NAME_BYTE;
              val_s[n[0]]  = {{(bst_pkg::VALUE_W-8){1'b0}}, src_byte};
              n = n + 2'd1;
            end else begin
              do_pend  = 1'b1;
              do_fresh = 1'b1;
            end
          end
          M_DOT: begin
            if (src_byte == CH_DOT) begin
              mode_nxt = M_DOT2;
            end else begin
              do_pend  = 1'b1;
              do_fresh = 1'b1;
            end
          end
          default: begin
            if ((mode_r == M_COLON) && (src_byte == CH_EQ))
              pair_kind = bst_pkg::K_ASSIGN;
            else if ((mode_r == M_COLON) && (src_byte == CH_COLON))
              pair_kind = bst_pkg::K_SCOPE;
            else if ((mode_r == M_DOT2) && (src_byte == CH_DOT))
              pair_kind = bst_pkg::K_DOT3;
            else if ((mode_r == M_BAR) && (src_byte == CH_BAR))
              pair_kind = bst_pkg::K_OROR;
            else if ((mode_r == M_BRACK) && (src_byte == CH_RBRK))
              pair_kind = bst_pkg::K_BRACKETS;
            else if ((mode_r == M_MINUS) && (src_byte == CH_GT))
              pair_kind = bst_pkg::K_ARROW;
            else if ((mode_r == M_EQ) && (src_byte == CH_EQ))
              pair_kind = bst_pkg::K_EQEQ;
            else if ((mode_r == M_LT) && (src_byte == CH_EQ))
              pair_kind = bst_pkg::K_LE;
            else if ((mode_r == M_GT) && (src_byte == CH_EQ))
              pair_kind = bst_pkg::K_GE;
            else if ((mode_r == M_BANG) && (src_byte == CH_EQ))
              pair_kind = bst_pkg::K_NE;

            if (pair_kind != bst_pkg::K_END) begin
              kind_s[n[0]] = pair_kind;
              n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              do_pend  = 1'b1;
              do_fresh = 1'b1;
            end
          end
        endcase
      end

      fr = fresh_f(src_byte, acc_nxt, kidx_nxt);

      if (do_pend) begin
        mode_nxt = M_IDLE;
        if (pd.emit) begin
          kind_s[n[0]] = pd.kind;
          val_s[n[0]]  = pd.value;
          n = n + 2'd1;
        end
      end
      if (do_fresh) begin
        mode_nxt = fr.mode;
        acc_nxt  = fr.acc;
        kidx_nxt = fr.kidx;
        if (fr.emit) begin
          kind_s[n[0]] = fr.kind;
          val_s[n[0]]  = fr.value;
          n = n + 2'd1;
        end
      end
      if (do_end) begin
        mode_nxt = M_DONE;
        kind_s[n[0]] = bst_pkg::K_END;
        val_s[n[0]]  = '0;
        n = n + 2'd1;
      end
    end else begin
      fr = fresh_f(src_byte, acc_r, kidx_r);
    end
  end

  always_comb begin
    pair.cnt        = n;
    pair.rec0.kind  = kind_s[0];
    pair.rec0.value = val_s[0];
    pair.rec0.line  = bst_pkg::POS_W'(line_nxt);
    pair.rec0.col   = bst_pkg::POS_W'(col_nxt);
    pair.rec0.last  = (n == 2'd1);
    pair.rec1.kind  = kind_s[1];
    pair.rec1.value = val_s[1];
    pair.rec1.line  = bst_pkg::POS_W'(line_nxt);
    pair.rec1.col   = bst_pkg::POS_W'(col_nxt);
    pair.rec1.last  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
      kidx_r <= '0;
      line_r <= POS_ONE;
      col_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      kidx_r <= kidx_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

>>> hw/rtl/bst_fifo.sv
// Short token queue between front and back: takes up to two records a cycle
// while room is high, gives one. Depends on bst_pkg.
module bst_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bst_pkg::tok_pair_t wr,
  input  logic               pop,
  output bst_pkg::q_head_t   head,
  output logic               room
);

  bst_pkg::tok_rec_t mem [bst_pkg::QDEPTH];

  logic [bst_pkg::QPTR_W-1:0] wp_r, wp_nxt;
  logic [bst_pkg::QPTR_W-1:0] rp_r, rp_nxt;
  logic [bst_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [bst_pkg::QCNT_W-1:0] n_in;
  logic                       do_pop;

  assign n_in   = push ? bst_pkg::QCNT_W'(wr.cnt) : '0;
  assign do_pop = pop && (cnt_r != '0);

  // room for a worst-case word of two records
  assign room       = (cnt_r <= bst_pkg::QCNT_W'(bst_pkg::QDEPTH - 2));
  assign head.avail = (cnt_r != '0);
  assign head.rec   = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + bst_pkg::QPTR_W'(n_in);
    rp_nxt  = rp_r + bst_pkg::QPTR_W'(do_pop);
    cnt_nxt = cnt_r + n_in - bst_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push && (wr.cnt != 2'd0)) mem[wp_r] <= wr.rec0;
    if (push && (wr.cnt == 2'd2)) mem[wp_r + bst_pkg::QPTR_W'(1)] <= wr.rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/bst_back.sv
// Back end: output register that drains the token queue onto the result stream.
// Depends on bst_pkg.
module bst_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bst_pkg::q_head_t            head,
  output logic                        pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bst_pkg::TDATA_W-1:0] out_tdata,
  output logic                        out_tlast
);

  logic              valid_r, valid_nxt;
  bst_pkg::tok_rec_t rec_r;

  assign pop = head.avail && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop)             valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) rec_r <= head.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = rec_r.last;
  assign out_tdata  = {4'b0000, rec_r.col, rec_r.line, rec_r.value, rec_r.kind};

endmodule

>>> hw/rtl/byte_stream_tokenizer_top.sv
// Top level of the byte stream tokenizer: front lexer, token queue, output stage.
// Depends on bst_pkg, bst_front, bst_fifo, bst_back.
//
//  channel | direction | tdata                          | tuser        | tlast
//  in_     | sink      | source_byte                    | end_of_input | -
//  out_    | source    | kind, value, line, column      | -            | last_of_run
//
// One input word per cycle while in_tready is high; each word yields 0 to 2 tokens,
// drained at one per cycle while out_tready is high. The lexer state updates in the
// cycle a word is accepted; tokens then pass the queue write and the output register.
// in_tready drops while the 4-entry queue has fewer than two free slots.
// Reset (rst_n low, synchronous) returns to line 1, column 0, between tokens.
// After the end token (or an unterminated string) input words are taken and dropped.
module byte_stream_tokenizer_top #(
  parameter int POSITION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] source_byte
  input  logic                        in_tuser,   // [0] end_of_input
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bst_pkg::TDATA_W-1:0] out_tdata,  // [4:0] token_kind, [67:5] token_value,
                                                  // [83:68] line_number,
                                                  // [99:84] column_number, [103:100] zero
  output logic                        out_tlast   // last_of_run
);

  logic               take;
  logic               room;
  logic               pop;
  bst_pkg::tok_pair_t pair;
  bst_pkg::q_head_t   head;

  assign in_tready = room;
  assign take      = in_tvalid && room;

  bst_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .src_byte (in_tdata),
    .eoi      (in_tuser),
    .pair     (pair)
  );

  bst_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .wr    (pair),
    .pop   (pop),
    .head  (head),
    .room  (room)
  );

  bst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/bst_token_checker.sv
`timescale 1ns / 100ps
// Token checker for byte_stream_tokenizer_top: follows both streams, predicts tokens
// from accepted source words and compares every output word. Depends on bst_pkg.
module bst_token_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] source_byte
  input  logic                        in_tuser,   // [0] end_of_input
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [bst_pkg::TDATA_W-1:0] out_tdata,  // [4:0] kind, [67:5] value, [83:68] line,
                                                  // [99:84] column, [103:100] zero
  input  logic                        out_tlast,
  output int                          fail_count,
  output int                          tokens_waiting,
  output int                          tokens_checked
);

  localparam logic [7:0]  B_NUL = 8'h00;
  localparam logic [7:0]  B_BEL = 8'h07;
  localparam logic [7:0]  B_BS  = 8'h08;
  localparam logic [7:0]  B_TAB = 8'h09;
  localparam logic [7:0]  B_NL  = 8'h0A;
  localparam logic [7:0]  B_VT  = 8'h0B;
  localparam logic [7:0]  B_FF  = 8'h0C;
  localparam logic [7:0]  B_CR  = 8'h0D;
  localparam logic [7:0]  B_ESC = 8'h1B;
  localparam logic [47:0] PRINTF_TEXT = "printf";
  localparam logic [2:0]  KW_LEN  = 3'd6;
  localparam logic [2:0]  KW_MISS = 3'd7;

  typedef enum logic [4:0] {
    L_IDLE, L_COMMENT, L_NUMBER, L_NAME, L_STRING, L_ESCAPE,
    L_COLON, L_DOT, L_DOT2, L_BAR, L_BRACK, L_MINUS, L_EQ, L_LT, L_GT,
    L_BANG, L_DONE
  } lex_mode_t;

  lex_mode_t                   mode;
  logic [bst_pkg::VALUE_W-1:0] num_acc;
  logic [2:0]                  kw_idx;
  logic [bst_pkg::POS_W-1:0]   line_no;
  logic [bst_pkg::POS_W-1:0]   col_no;

  bst_pkg::tok_rec_t expected_tokens[$];
  bst_pkg::tok_rec_t word_tokens[$];
  int                fails = 0;
  int                checked = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // bytes from 0x80 up count as name bytes
  function automatic bit is_name_start(logic [7:0] c);
    return c == "_" || c >= 8'h80 || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void emit(logic [bst_pkg::KIND_W-1:0] kind,
                               logic [bst_pkg::VALUE_W-1:0] value);
    bst_pkg::tok_rec_t t;
    t.kind  = kind;
    t.value = value;
    t.line  = line_no;
    t.col   = col_no;
    t.last  = 1'b0;
    word_tokens = {word_tokens, t};
  endfunction

  function automatic void emit_byte(logic [bst_pkg::KIND_W-1:0] kind, logic [7:0] c);
    emit(kind, bst_pkg::VALUE_W'(c));
  endfunction

  function automatic void track_printf(logic [7:0] c);
    int k;
    k = kw_idx;
    if (kw_idx < KW_LEN && c == PRINTF_TEXT[47 - 8 * k -: 8]) kw_idx = kw_idx + 1'b1;
    else kw_idx = KW_MISS;
  endfunction

  function automatic void take_string_byte(logic [7:0] c);
    if (c == "\"") begin
      emit(bst_pkg::K_STR_END, '0);
      mode = L_IDLE;
    end else if (c == "\\") begin
      mode = L_ESCAPE;
    end else begin
      emit_byte(bst_pkg::K_STR_BYTE, c);
    end
  endfunction

  // token held back by a lookahead, number or name state
  function automatic void flush_held();
    case (mode)
      L_COLON:  emit_byte(bst_pkg::K_CHAR, ":");
      L_DOT:    emit_byte(bst_pkg::K_CHAR, ".");
      L_DOT2:   emit(bst_pkg::K_DOT2, '0);
      L_BAR:    emit_byte(bst_pkg::K_CHAR, "|");
      L_BRACK:  emit_byte(bst_pkg::K_CHAR, "[");
      L_MINUS:  emit_byte(bst_pkg::K_CHAR, "-");
      L_EQ:     emit_byte(bst_pkg::K_CHAR, "=");
      L_LT:     emit(bst_pkg::K_LT, '0);
      L_GT:     emit(bst_pkg::K_GT, '0);
      L_BANG:   emit_byte(bst_pkg::K_CHAR, "!");
      L_NUMBER: emit(bst_pkg::K_NUMBER, num_acc);
      L_NAME:   emit(kw_idx == KW_LEN ? bst_pkg::K_PRINTF : bst_pkg::K_NAME_END, '0);
      default: ;
    endcase
    mode = L_IDLE;
  endfunction

  function automatic void take_fresh(logic [7:0] c);
    mode = L_IDLE;
    case (c)
      B_NUL: begin
        emit(bst_pkg::K_END, '0);
        mode = L_DONE;
      end
      " ", B_TAB, B_FF, B_CR, B_NL, B_VT: ;
      "#":  mode = L_COMMENT;
      ":":  mode = L_COLON;
      ".":  mode = L_DOT;
      "|":  mode = L_BAR;
      "[":  mode = L_BRACK;
      "-":  mode = L_MINUS;
      "=":  mode = L_EQ;
      "<":  mode = L_LT;
      ">":  mode = L_GT;
      "!":  mode = L_BANG;
      "\"": mode = L_STRING;
      default: begin
        if (is_digit(c)) begin
          num_acc = bst_pkg::VALUE_W'(c - 8'h30);
          mode = L_NUMBER;
        end else if (is_name_start(c)) begin
          kw_idx = '0;
          track_printf(c);
          emit_byte(bst_pkg::K_NAME_BYTE, c);
          mode = L_NAME;
        end else begin
          emit_byte(bst_pkg::K_CHAR, c);
        end
      end
    endcase
  endfunction

  // tokens caused by one accepted source word
  function automatic void predict_word(logic [7:0] c, logic eoi);
    logic [63:0]                digit;
    logic [7:0]                 esc;
    bit                         known;
    bit                         hit;
    logic [bst_pkg::KIND_W-1:0] pair;
    word_tokens.delete();
    if (mode == L_DONE) return;
    if (eoi) begin
      if (mode == L_STRING || mode == L_ESCAPE) begin
        if (mode == L_ESCAPE) emit(bst_pkg::K_BAD_ESC, '0);
        emit(bst_pkg::K_UNTERM, '0);
      end else begin
        flush_held();
        emit(bst_pkg::K_END, '0);
      end
      mode = L_DONE;
    end else begin
      if (c == B_NL) begin
        line_no = line_no + 1'b1;
        col_no  = '0;
      end else begin
        col_no = col_no + 1'b1;
      end
      case (mode)
        L_IDLE: take_fresh(c);
        L_COMMENT: if (c == B_NL) mode = L_IDLE;
        L_STRING: take_string_byte(c);
        L_ESCAPE: begin
          known = 1'b1;
          esc   = c;
          case (c)
            "\\", "'", "\"": esc = c;
            "0": esc = B_NUL;
            "n": esc = B_NL;
            "t": esc = B_TAB;
            "r": esc = B_CR;
            "f": esc = B_FF;
            "v": esc = B_VT;
            "a": esc = B_BEL;
            "e": esc = B_ESC;
            "b": esc = B_BS;
            default: known = 1'b0;
          endcase
          mode = L_STRING;
          if (known) begin
            emit_byte(bst_pkg::K_STR_BYTE, esc);
          end else begin
            // error word, then the byte is string content again
            emit_byte(bst_pkg::K_BAD_ESC, c);
            take_string_byte(c);
          end
        end
        L_NUMBER: begin
          if (is_digit(c)) begin
            digit = 64'(c - 8'h30);
            if ({1'b0, num_acc} > ({1'b0, bst_pkg::NUM_MAX} - digit) / 10)
              num_acc = bst_pkg::NUM_MAX;
            else
              num_acc = bst_pkg::VALUE_W'(num_acc * 10 + digit);
          end else begin
            flush_held();
            take_fresh(c);
          end
        end
        L_NAME: begin
          if (is_name_start(c) || is_digit(c)) begin
            track_printf(c);
            emit_byte(bst_pkg::K_NAME_BYTE, c);
          end else begin
            flush_held();
            take_fresh(c);
          end
        end
        L_DOT: begin
          if (c == ".") begin
            mode = L_DOT2;
          end else begin
            flush_held();
            take_fresh(c);
          end
        end
        default: begin
          hit  = 1'b1;
          pair = bst_pkg::K_END;
          if (mode == L_COLON && c == "=") pair = bst_pkg::K_ASSIGN;
          else if (mode == L_COLON && c == ":") pair = bst_pkg::K_SCOPE;
          else if (mode == L_DOT2 && c == ".") pair = bst_pkg::K_DOT3;
          else if (mode == L_BAR && c == "|") pair = bst_pkg::K_OROR;
          else if (mode == L_BRACK && c == "]") pair = bst_pkg::K_BRACKETS;
          else if (mode == L_MINUS && c == ">") pair = bst_pkg::K_ARROW;
          else if (mode == L_EQ && c == "=") pair = bst_pkg::K_EQEQ;
          else if (mode == L_LT && c == "=") pair = bst_pkg::K_LE;
          else if (mode == L_GT && c == "=") pair = bst_pkg::K_GE;
          else if (mode == L_BANG && c == "=") pair = bst_pkg::K_NE;
          else hit = 1'b0;
          if (hit) begin
            emit(pair, '0);
            mode = L_IDLE;
          end else begin
            flush_held();
            take_fresh(c);
          end
        end
      endcase
    end
    if (word_tokens.size() > 0) word_tokens[word_tokens.size() - 1].last = 1'b1;
    foreach (word_tokens[i]) expected_tokens = {expected_tokens, word_tokens[i]};
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : watch
    bst_pkg::tok_rec_t want;
    if (!rst_n) begin
      mode    = L_IDLE;
      num_acc = '0;
      kw_idx  = '0;
      line_no = bst_pkg::POS_W'(1);
      col_no  = '0;
      expected_tokens.delete();
    end else begin
      if (in_tvalid && in_tready) predict_word(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("token_kind: expected none, actual %0d", out_tdata[4:0]);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          compare_field("token_kind", 64'(want.kind), 64'(out_tdata[4:0]));
          compare_field("token_value", 64'(want.value), 64'(out_tdata[67:5]));
          compare_field("line_number", 64'(want.line), 64'(out_tdata[83:68]));
          compare_field("column_number", 64'(want.col), 64'(out_tdata[99:84]));
          compare_field("pad", '0, 64'(out_tdata[103:100]));
          compare_field("last_of_run", 64'(want.last), 64'(out_tlast));
          checked++;
        end
      end
    end
    tokens_waiting <= expected_tokens.size();
    fail_count     <= fails;
    tokens_checked <= checked;
  end

endmodule

>>> tb/tb_byte_stream_tokenizer_top.sv
`timescale 1ns / 100ps
// Top of the byte stream tokenizer testbench: clock, reset, source text stimulus,
// output back-pressure and verdict. Depends on bst_pkg, the DUT and bst_token_checker.
module tb_byte_stream_tokenizer_top;

  localparam int HALF_PERIOD = 2;
  localparam int QUIET_LIMIT = 2000;
  localparam int FRAGMENTS   = 380;
  localparam int MAX_WAIT    = 14;

  localparam logic [7:0]  B_NUL = 8'h00;
  localparam logic [7:0]  B_TAB = 8'h09;
  localparam logic [7:0]  B_NL  = 8'h0A;
  localparam logic [7:0]  B_VT  = 8'h0B;
  localparam logic [7:0]  B_FF  = 8'h0C;
  localparam logic [7:0]  B_CR  = 8'h0D;
  localparam logic [47:0] SPACE_SET = {" ", B_TAB, B_FF, B_CR, B_NL, B_VT};

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [7:0]                  in_tdata = '0;
  logic                        in_tuser = 1'b0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [bst_pkg::TDATA_W-1:0] out_tdata;
  logic                        out_tlast;

  int    fail_count;
  int    tokens_waiting;
  int    tokens_checked;
  int    words_sent = 0;
  int    quiet_cycles = 0;
  bit    idling = 1'b1;
  string ending = "";
  string op_starts = ":.|[-=<>!";
  string escapes = "\\0ntrfvaeb'\"";

  always #HALF_PERIOD clk = ~clk;

  byte_stream_tokenizer_top #(.POSITION_BITS(bst_pkg::POS_W)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  bst_token_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .tokens_waiting (tokens_waiting),
    .tokens_checked (tokens_checked)
  );

  // valid stays high between back-to-back words
  task automatic send_word(logic [7:0] b, logic eoi);
    int gap;
    gap = idling ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  function automatic logic [7:0] name_byte(bit more);
    case ($urandom_range(0, more ? 4 : 3))
      0: return "a" + $urandom_range(0, 25);
      1: return "A" + $urandom_range(0, 25);
      2: return $urandom_range(128, 255);
      3: return "_";
      default: return "0" + $urandom_range(0, 9);
    endcase
  endfunction

  // quotes and hashes only come from whole string and comment runs, so a zero byte
  // never lands between tokens
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = $urandom_range(1, 255); while (b == "\"" || b == "#");
    return b;
  endfunction

  task automatic send_fragment(int sel);
    logic [7:0] b;
    logic [7:0] second;
    if (sel < 15) begin
      repeat ($urandom_range(1, 3)) send_word(SPACE_SET[8 * $urandom_range(0, 5) +: 8], 1'b0);
    end else if (sel < 25) begin
      send_word("#", 1'b0);
      repeat ($urandom_range(0, 8)) begin
        b = $urandom_range(0, 255);
        if (b == B_NL) b = B_NUL;
        send_word(b, 1'b0);
      end
      send_word(B_NL, 1'b0);
    end else if (sel < 40) begin
      send_word("\"", 1'b0);
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(0, 4) == 0) begin
          send_word("\\", 1'b0);
          if ($urandom_range(0, 2) != 0) b = escapes[$urandom_range(0, escapes.len() - 1)];
          else b = $urandom_range(0, 255);
          send_word(b, 1'b0);
        end else begin
          b = $urandom_range(0, 255);
          if (b == "\"" || b == "\\") b = B_NUL;
          send_word(b, 1'b0);
        end
      end
      send_word("\"", 1'b0);
    end else if (sel < 55) begin
      // mostly short numbers, now and then long enough to saturate
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(19, 24) : $urandom_range(1, 6)) begin
        b = "0" + $urandom_range(0, 9);
        send_word(b, 1'b0);
      end
    end else if (sel < 70) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: send_text("printf");
          1: send_text("print");
          2: send_text("printf_");
          3: send_text("prinTf");
          default: send_text("printf9");
        endcase
      end else begin
        send_word(name_byte(1'b0), 1'b0);
        repeat ($urandom_range(0, 7)) send_word(name_byte(1'b1), 1'b0);
      end
    end else if (sel < 85) begin
      b = op_starts[$urandom_range(0, op_starts.len() - 1)];
      send_word(b, 1'b0);
      if ($urandom_range(0, 1) == 1) begin
        case (b)
          ":": second = $urandom_range(0, 1) ? "=" : ":";
          ".": second = ".";
          "|": second = "|";
          "[": second = "]";
          "-": second = ">";
          default: second = "=";
        endcase
        send_word(second, 1'b0);
        if (b == "." && $urandom_range(0, 1) == 1) send_word(".", 1'b0);
      end
    end else if (sel < 95) begin
      send_word(plain_byte(), 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) send_word(plain_byte(), 1'b0);
    end
  endtask

  initial begin : drain
    int stall;
    forever begin
      stall = idling ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL byte_stream_tokenizer_top");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every operator but the two-dot one, a bad escape, a zero inside a string, the keyword
    send_text(":=::...||[]->==<=>=!=<>\"\\q\\e");
    send_word(B_NUL, 1'b0);
    send_text("\"printf ");

    for (int i = 0; i < FRAGMENTS; i++) begin
      if ($urandom_range(0, 39) == 0) idling = !idling;
      send_fragment($urandom_range(0, 99));
    end
    idling = 1'b1;

    case ($urandom_range(0, 3))
      0: begin
        ending = "zero byte after a name";
        send_text("x");
        send_word(B_NUL, 1'b0);
      end
      1: begin
        ending = "end mark with a pending operator";
        send_text("7=");
        send_word($urandom_range(0, 255), 1'b1);
      end
      2: begin
        ending = "end mark inside a string";
        send_text("\"a");
        send_word($urandom_range(0, 255), 1'b1);
      end
      default: begin
        ending = "end mark inside an escape";
        send_text("\"\\");
        send_word($urandom_range(0, 255), 1'b1);
      end
    endcase
    // words after the end are dropped
    repeat (3) send_word($urandom_range(0, 255), $urandom_range(0, 1));
    send_word($urandom_range(0, 255), 1'b1);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (tokens_waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d source words with random gaps and bursts, finishing with %s.",
             words_sent, ending);
    $display("Compared %0d tokens over operators, strings, numbers and names: %0d mismatches.",
             tokens_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS byte_stream_tokenizer_top");
    end else begin
      $display("FAIL byte_stream_tokenizer_top");
    end
    $finish;
  end

endmodule
